>>> rtl/mun_pkg.sv
`default_nettype none
package mun_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int CoordW = 24;
  localparam int SqW = 50;   // x^2+y^2+z^2+2^32 < 2^50
  localparam int RootW = 25; // sqrt of SqW bits
  localparam int QuoW = 17;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } vtx_t;
endpackage
`default_nettype wire

>>> rtl/mesh_unit_normalizer.sv
`default_nettype none
// channel | handshake             | payload
// in      | valid / stall         | pos_x, pos_y, pos_z, last
// out     | out_valid / out_stall | norm_x/y/z, vertex_index, end_of_mesh, dropped
// Loading: one vertex per cycle (store write + min update).
// Final pass: squared-length scan per vertex (a read, then square and
// accumulate per axis), then the square root.
// Output: per vertex a read, 3 divisions (one per axis) and the emit
// state, which holds while the output is stalled.
// Synchronous reset clears counters and minima; the store needs no clearing.
// A stalled output holds; input stalls for the whole pass.
module mesh_unit_normalizer (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid,
  output logic stall,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic signed [23:0] pos_z,
  input  wire logic last,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [16:0] norm_x,
  output logic [16:0] norm_y,
  output logic [16:0] norm_z,
  output logic [5:0] vertex_index,
  output logic end_of_mesh,
  output logic dropped
);
  import mun_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_SRD, S_SQ, S_SACC, S_ROOT, S_RWAIT, S_DRD, S_DIV, S_DWAIT, S_EMIT
  } state_t;

  state_t state;
  vtx_t store [MaxPoints];
  vtx_t rd;
  logic [CntW-1:0] count;
  logic [IdxW-1:0] idx;
  logic [1:0] axis;
  logic signed [CoordW-1:0] min_x, min_y, min_z;
  logic ovf;
  logic [SqW-1:0] acc, best;
  logic [CoordW-1:0] ucoord;
  logic [2*CoordW-1:0] sq;
  logic [RootW-1:0] radius;
  logic sq_start, sq_done, dv_start, dv_done;
  logic [RootW-1:0] root;
  logic [QuoW-1:0] quo;
  logic accept;

  assign accept = valid && !stall;
  assign stall = (state != S_LOAD);

  // memory read port, registered
  always_ff @(posedge clk) begin
    if (accept && count != CntW'(MaxPoints))
      store[count[IdxW-1:0]] <= '{x: pos_x, y: pos_y, z: pos_z};
    rd <= store[idx];
  end

  // shifted coordinate of the current axis
  always_comb begin
    case (axis)
      2'd0: ucoord = CoordW'(rd.x - min_x);
      2'd1: ucoord = CoordW'(rd.y - min_y);
      default: ucoord = CoordW'(rd.z - min_z);
    endcase
  end

  mun_sqrt u_sqrt (.clk, .rst, .start(sq_start), .radicand(best), .done(sq_done),
    .root(root));
  mun_div u_div (.clk, .rst, .start(dv_start), .coord(ucoord), .divisor(radius),
    .done(dv_done), .quo(quo));

  assign sq_start = (state == S_ROOT);
  assign dv_start = (state == S_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      min_x <= '0;
      min_y <= '0;
      min_z <= '0;
      ovf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: if (accept) begin
          if (count != CntW'(MaxPoints)) begin
            count <= count + 1'b1;
            if (pos_x < min_x) min_x <= pos_x;
            if (pos_y < min_y) min_y <= pos_y;
            if (pos_z < min_z) min_z <= pos_z;
          end else begin
            ovf <= 1'b1;
          end
          if (last) begin
            idx <= '0;
            best <= '0;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          axis <= 2'd0;
          acc <= SqW'(64'h1_0000_0000);
          state <= S_SQ;
        end
        // square of the current axis, registered, then accumulated before the next square
        S_SQ: begin
          sq <= ucoord * ucoord;
          state <= S_SACC;
        end
        S_SACC: begin
          if (axis == 2'd2) begin
            if (acc + SqW'(sq) > best) best <= acc + SqW'(sq);
            if (CntW'(idx) + 1'b1 == count) begin
              state <= S_ROOT;
            end else begin
              idx <= idx + 1'b1;
              state <= S_SRD;
            end
          end else begin
            acc <= acc + SqW'(sq);
            axis <= axis + 1'b1;
            state <= S_SQ;
          end
        end
        S_ROOT: state <= S_RWAIT;
        S_RWAIT: if (sq_done) begin
          radius <= root;
          idx <= '0;
          state <= S_DRD;
        end
        S_DRD: begin
          axis <= 2'd0;
          state <= S_DIV;
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: if (dv_done) begin
          case (axis)
            2'd0: norm_x <= quo;
            2'd1: norm_y <= quo;
            default: norm_z <= quo;
          endcase
          if (axis == 2'd2) begin
            vertex_index <= idx;
            end_of_mesh <= (CntW'(idx) + 1'b1 == count);
            dropped <= ovf;
            out_valid <= 1'b1;
            state <= S_EMIT;
          end else begin
            axis <= axis + 1'b1;
            state <= S_DIV;
          end
        end
        S_EMIT: if (!out_stall) begin
          out_valid <= 1'b0;
          if (end_of_mesh) begin
            count <= '0;
            min_x <= '0;
            min_y <= '0;
            min_z <= '0;
            ovf <= 1'b0;
            state <= S_LOAD;
          end else begin
            idx <= idx + 1'b1;
            state <= S_DRD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/mun_sqrt.sv
`default_nettype none
// Bit-serial integer square root, one result bit per cycle.
module mun_sqrt (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [mun_pkg::SqW-1:0] radicand,
  output logic done,
  output logic [mun_pkg::RootW-1:0] root
);
  import mun_pkg::*;
  localparam int StepW = $clog2(RootW + 1);

  logic [SqW+1:0] rem;
  logic [SqW-1:0] num;
  logic [StepW-1:0] step;
  logic busy;
  logic [SqW+1:0] trial;
  logic [SqW+1:0] shifted;

  // restoring method: bring down two bits, try root*4+1
  always_comb begin
    shifted = {rem[SqW-1:0], num[SqW-1 -: 2]};
    trial = {{(SqW+2-RootW-2){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        num <= radicand;
        root <= '0;
        step <= StepW'(RootW);
      end else if (busy) begin
        num <= num << 2;
        if (shifted >= trial) begin
          rem <= shifted - trial;
          root <= {root[RootW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          root <= {root[RootW-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/mun_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
module mun_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [mun_pkg::CoordW-1:0] coord,
  input  wire logic [mun_pkg::RootW-1:0] divisor,
  output logic done,
  output logic [mun_pkg::QuoW-1:0] quo
);
  import mun_pkg::*;
  localparam int StepW = $clog2(QuoW + 1);

  // quotient < 2^17, so start with coord<<16 >> 17 as partial remainder
  logic [RootW:0] rem;
  logic [QuoW-1:0] low;
  logic [StepW-1:0] step;
  logic busy;
  logic [RootW+1:0] sh;

  assign sh = {rem, low[QuoW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= (RootW+1)'(coord[CoordW-1:1]);
        low <= {coord[0], 16'h0};
        quo <= '0;
        step <= StepW'(QuoW);
      end else if (busy) begin
        low <= low << 1;
        if (sh >= {1'b0, 1'b0, divisor}) begin
          rem <= (RootW+1)'(sh - {2'b0, divisor});
          quo <= {quo[QuoW-2:0], 1'b1};
        end else begin
          rem <= sh[RootW:0];
          quo <= {quo[QuoW-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/mun_checker.sv
`default_nettype none
module mun_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic valid,
  input wire logic stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [16:0] norm_x,
  input wire logic [16:0] norm_y,
  input wire logic [16:0] norm_z,
  input wire logic [5:0] vertex_index
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(norm_x) && $stable(vertex_index))
    else $error("stalled item changed");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_x <= 17'd65536 && norm_y <= 17'd65536 && norm_z <= 17'd65536)
    else $error("normalized value above one");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stall)
    else $error("input open while results pending");
endmodule
bind mesh_unit_normalizer mun_checker u_chk (.clk, .rst, .valid, .stall, .out_valid,
  .out_stall, .norm_x, .norm_y, .norm_z, .vertex_index);
`default_nettype wire
